### hw/rtl/wsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, derived sizes and inter-stage types for the windowed slope
// peak block.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int WINDOW_LENGTH = 10;
    localparam int SAMPLE_W      = 16;
    localparam int DIFF_W        = 16;
    localparam int PEAK_W        = 20;

    // Running totals are sized for a full window of maximum differences.
    localparam int TOTAL_W = $clog2(WINDOW_LENGTH * (2 ** DIFF_W - 1) + 1);
    localparam int PTR_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_LENGTH + 1);
    localparam int SAT_W   = (TOTAL_W > PEAK_W) ? TOTAL_W : PEAK_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [DIFF_W-1:0]   t_diff;
    typedef logic        [PEAK_W-1:0]   t_peak;
    typedef logic        [TOTAL_W-1:0]  t_total;
    typedef logic        [PTR_W-1:0]    t_ptr;
    typedef logic        [CNT_W-1:0]    t_cnt;

    // Slope stage output toward the window accumulator.
    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        t_diff diff;
    } t_slope_stage;

endpackage : wsp_pkg
`default_nettype wire

### hw/rtl/wsp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_in_if
// Sample channel: valid/ready handshake carrying one sample word.
// ----------------------------------------------------------------------------
interface wsp_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      sample;
    logic                    first;
    logic                    last;

    modport source (output valid, output sample, output first, output last, input ready);
    modport sink   (input valid, input sample, input first, input last, output ready);
endinterface : wsp_in_if
`default_nettype wire

### hw/rtl/wsp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_out_if
// Result channel: valid/ready handshake carrying one peak word.
// ----------------------------------------------------------------------------
interface wsp_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] peak_window_sum;

    modport source (output valid, output peak_window_sum, input ready);
    modport sink   (input valid, input peak_window_sum, output ready);
endinterface : wsp_out_if
`default_nettype wire

### hw/rtl/wsp_slope.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_slope
// Input register stage: takes a sample word, forms the absolute difference
// against the previous sample and hands it to the window accumulator.
// ----------------------------------------------------------------------------
module wsp_slope (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    wsp_in_if.sink                     i_smp,
    input  wire logic                  i_advance,
    output wsp_pkg::t_slope_stage      o_stage
);
    import wsp_pkg::*;

    t_sample             r_prev;
    t_sample             n_prev;
    t_slope_stage        r_stage;
    t_slope_stage        n_stage;
    logic                accept;
    logic [SAMPLE_W:0]   delta;
    logic [SAMPLE_W:0]   magnitude;

    assign i_smp.ready = !r_stage.valid || i_advance;
    assign accept      = i_smp.valid && i_smp.ready;

    always_comb begin
        delta     = {i_smp.sample[SAMPLE_W-1], i_smp.sample} - {r_prev[SAMPLE_W-1], r_prev};
        magnitude = delta[SAMPLE_W] ? (~delta + 1'b1) : delta;
    end

    always_comb begin
        n_prev  = r_prev;
        n_stage = r_stage;
        if (accept) begin
            n_prev        = i_smp.sample;
            n_stage.valid = 1'b1;
            n_stage.first = i_smp.first;
            n_stage.last  = i_smp.last;
            n_stage.diff  = magnitude[DIFF_W-1:0];
        end else if (i_advance) begin
            n_stage.valid = 1'b0;
        end
    end

    // Only the valid bit of the stage register is reset; the payload holds until the next word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_stage.valid <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule : wsp_slope
`default_nettype wire

### hw/rtl/wsp_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_window
// Window accumulator: keeps the difference ring, the running window total and
// the peak total, and registers the saturated peak on the last word.
// ----------------------------------------------------------------------------
module wsp_window (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire wsp_pkg::t_slope_stage i_stage,
    output logic                       o_advance,
    wsp_out_if.source                  o_res
);
    import wsp_pkg::*;

    t_diff        r_ring [WINDOW_LENGTH];
    t_ptr         r_ptr;
    t_ptr         n_ptr;
    t_cnt         r_count;
    t_cnt         n_count;
    t_total       r_total;
    t_total       n_total;
    t_total       r_best;
    t_total       n_best;
    logic         r_out_valid;
    logic         n_out_valid;
    t_peak        r_peak;
    t_peak        n_peak;
    logic         full;
    t_diff        evicted;
    logic [SAT_W-1:0] best_ext;

    // Only a word marked last needs the result register.
    assign o_advance = i_stage.valid && (!i_stage.last || !r_out_valid || o_res.ready);

    assign full    = (r_count == CNT_W'(WINDOW_LENGTH));
    assign evicted = full ? r_ring[r_ptr] : '0;

    always_comb begin
        n_ptr   = r_ptr;
        n_count = r_count;
        n_total = r_total;
        n_best  = r_best;
        if (o_advance) begin
            if (i_stage.first) begin
                n_ptr   = '0;
                n_count = '0;
                n_total = '0;
                n_best  = '0;
            end else begin
                n_total = r_total - TOTAL_W'(evicted) + TOTAL_W'(i_stage.diff);
                n_count = full ? r_count : r_count + CNT_W'(1);
                n_ptr   = (r_ptr == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : r_ptr + PTR_W'(1);
                n_best  = (n_total > r_best) ? n_total : r_best;
            end
        end
    end

    always_comb begin
        best_ext    = SAT_W'(n_best);
        n_out_valid = r_out_valid;
        n_peak      = r_peak;
        if (o_advance && i_stage.last) begin
            n_out_valid = 1'b1;
            // Clamp to the result width.
            n_peak = (best_ext > SAT_W'({PEAK_W{1'b1}})) ? {PEAK_W{1'b1}}
                                                         : best_ext[PEAK_W-1:0];
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_total     <= n_total;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    // Ring entries are read only after being written in this measurement.
    always_ff @(posedge i_clk) begin
        r_peak <= n_peak;
        if (o_advance && !i_stage.first) begin
            r_ring[r_ptr] <= i_stage.diff;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.peak_window_sum = r_peak;

endmodule : wsp_window
`default_nettype wire

### hw/rtl/windowed_slope_peak_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_slope_peak_top
// Peak of a sliding sum of absolute sample-to-sample differences.
// A word marked last, once taken, is held in the slope register; the result
// register then loads the saturated peak and raises valid.
// Throughput: one sample word per cycle; only a last word waits while an
// untaken result still holds the result register.
// Reset clears the previous sample, ring pointer, fill count and totals;
// ring contents are not cleared and are read only once rewritten.
// ----------------------------------------------------------------------------
module windowed_slope_peak_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wsp_in_if.sink       i_smp,
    wsp_out_if.source    o_res
);
    import wsp_pkg::*;

    t_slope_stage stage;
    logic         advance;

    wsp_slope u_slope (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (i_smp),
        .i_advance (advance),
        .o_stage   (stage)
    );

    wsp_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule : windowed_slope_peak_top
`default_nettype wire
